### design/ppst_pkg.sv
// Shared types and constants for the per-process sleep timer table.
package ppst_pkg;

  localparam int TICKS_W    = 16;
  localparam int IN_SLOT_W  = 4;
  localparam int OUT_SLOT_W = 4;

  localparam logic OP_ARM  = 1'b0;
  localparam logic OP_TICK = 1'b1;

  localparam logic [TICKS_W-1:0] TICKS_ONE = TICKS_W'(1);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FLUSH
  } state_t;

endpackage

### design/ppst_mem.sv
// Counter RAM: one sleep count per slot, registered read, per-entry valid bits.
module ppst_mem #(
  parameter int NUM_SLOTS = 16,
  parameter int SLOT_W    = 4
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         rd_en,
  input  logic [SLOT_W-1:0]            rd_addr,
  output logic [ppst_pkg::TICKS_W-1:0] rd_data,
  input  logic                         wr_en,
  input  logic [SLOT_W-1:0]            wr_addr,
  input  logic [ppst_pkg::TICKS_W-1:0] wr_data
);
  import ppst_pkg::*;

  logic [TICKS_W-1:0] mem [NUM_SLOTS];
  logic [NUM_SLOTS-1:0] live;
  logic [TICKS_W-1:0] rd_q;
  logic               rd_live;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_q <= mem[rd_addr];
    end
  end

  // An entry never written since reset reads as zero.
  always_ff @(posedge clk) begin
    if (rst) begin
      live    <= '0;
      rd_live <= 1'b0;
    end else begin
      if (wr_en) begin
        live[wr_addr] <= 1'b1;
      end
      if (rd_en) begin
        rd_live <= live[rd_addr];
      end
    end
  end

  assign rd_data = rd_live ? rd_q : '0;

endmodule

### design/ppst_ctrl.sv
// Sequencer: arm writes, tick scan with read-modify-write, wake queueing and output register.
module ppst_ctrl #(
  parameter int NUM_SLOTS = 16,
  parameter int SLOT_W    = 4,
  parameter int CNT_W     = 5
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic                            operation,
  input  logic [ppst_pkg::IN_SLOT_W-1:0]  process_slot,
  input  logic [ppst_pkg::TICKS_W-1:0]    sleep_ticks,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [ppst_pkg::OUT_SLOT_W-1:0] woken_slot,
  output logic                            last_wake,
  output logic                            rd_en,
  output logic [SLOT_W-1:0]               rd_addr,
  input  logic [ppst_pkg::TICKS_W-1:0]    rd_data,
  output logic                            wr_en,
  output logic [SLOT_W-1:0]               wr_addr,
  output logic [ppst_pkg::TICKS_W-1:0]    wr_data
);
  import ppst_pkg::*;

  localparam logic [CNT_W-1:0] LAST_IDX = CNT_W'(NUM_SLOTS);

  state_t state, state_next;

  logic [CNT_W-1:0]  rd_idx;
  logic              s1_vld;
  logic [SLOT_W-1:0] s1_idx;
  logic              pend_vld;
  logic [SLOT_W-1:0] pend_slot;

  logic in_fire, out_free, wake, stall, adv, issue;
  logic scanning, flushing, scan_done, flush_emit, emit_mid;
  logic arm_wr, scan_wr, slot_ok;

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_fire && operation == OP_TICK) begin
          state_next = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (scan_done) begin
          state_next = ST_FLUSH;
        end
      end
      ST_FLUSH: begin
        if (!pend_vld || out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // State decode
  always_comb begin
    in_ready = 1'b0;
    scanning = 1'b0;
    flushing = 1'b0;
    unique case (state)
      ST_IDLE:  in_ready = 1'b1;
      ST_SCAN:  scanning = 1'b1;
      ST_FLUSH: flushing = 1'b1;
      default:  in_ready = 1'b0;
    endcase
  end

  always_comb begin
    in_fire  = in_valid && in_ready;
    out_free = !out_valid || out_ready;
    wake     = s1_vld && (rd_data == TICKS_ONE);
    // Hold the scan when a second wake arrives and the output is still busy.
    stall    = wake && pend_vld && !out_free;
    adv      = s1_vld && !stall;
    issue    = scanning && !stall && (rd_idx != LAST_IDX);
    scan_done  = scanning && (rd_idx == LAST_IDX) && !s1_vld;
    flush_emit = flushing && pend_vld && out_free;
    emit_mid   = adv && wake && pend_vld;
    slot_ok  = 32'(process_slot) < NUM_SLOTS;
    arm_wr   = in_fire && operation == OP_ARM && slot_ok;
    scan_wr  = adv && (rd_data != '0);
  end

  always_comb begin
    rd_en   = issue;
    rd_addr = rd_idx[SLOT_W-1:0];
    wr_en   = arm_wr || scan_wr;
    if (scan_wr) begin
      wr_addr = s1_idx;
      wr_data = rd_data - TICKS_ONE;
    end else begin
      wr_addr = SLOT_W'(process_slot);
      wr_data = sleep_ticks;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      rd_idx    <= '0;
      s1_vld    <= 1'b0;
      pend_vld  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;

      if (in_fire) begin
        rd_idx <= '0;
      end else if (issue) begin
        rd_idx <= rd_idx + CNT_W'(1);
      end

      if (issue) begin
        s1_vld <= 1'b1;
      end else if (adv) begin
        s1_vld <= 1'b0;
      end

      if (adv && wake) begin
        pend_vld <= 1'b1;
      end else if (flush_emit) begin
        pend_vld <= 1'b0;
      end

      if (emit_mid || flush_emit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (issue) begin
      s1_idx <= rd_idx[SLOT_W-1:0];
    end
    if (adv && wake) begin
      pend_slot <= s1_idx;
    end
    if (emit_mid) begin
      woken_slot <= OUT_SLOT_W'(pend_slot);
      last_wake  <= 1'b0;
    end else if (flush_emit) begin
      woken_slot <= OUT_SLOT_W'(pend_slot);
      last_wake  <= 1'b1;
    end
  end

`ifndef ASSERT_OFF
  a_idle_no_pend: assert property (@(posedge clk) disable iff (rst)
    state == ST_IDLE |-> !pend_vld)
    else $error("wake left pending in idle");

  a_s1_in_scan: assert property (@(posedge clk) disable iff (rst)
    s1_vld |-> state == ST_SCAN)
    else $error("read stage active outside scan");

  a_idx_range: assert property (@(posedge clk) disable iff (rst)
    rd_idx <= LAST_IDX)
    else $error("scan index past table");

  a_flush_no_write: assert property (@(posedge clk) disable iff (rst)
    state == ST_FLUSH |-> !wr_en)
    else $error("counter write during flush");

  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    stall |=> s1_vld && $stable(s1_idx))
    else $error("stalled slot lost");
`endif

endmodule

### design/per_process_sleep_timer_table.sv
// An arm item (operation 0) loads sleep_ticks into process_slot's counter and gives no
// result; slots at or beyond NUM_SLOTS are ignored. A tick item (operation 1) walks the
// counter RAM one slot per cycle unless the scan stalls on a busy output, read then write
// back. It holds in_ready low through the scan and the flush of its last wake, and for as
// long as the output is held by out_ready. Each slot that reaches zero yields one item
// with its index, in ascending order; the final one of a tick carries last_wake, and a
// tick that wakes nobody yields nothing. The output register lets a new item be accepted
// while the last result is still waiting. Counters read as zero after reset through
// per-slot valid bits, so there is no clearing pass.
module per_process_sleep_timer_table #(
  parameter int NUM_SLOTS = 16
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic                            operation,
  input  logic [ppst_pkg::IN_SLOT_W-1:0]  process_slot,
  input  logic [ppst_pkg::TICKS_W-1:0]    sleep_ticks,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [ppst_pkg::OUT_SLOT_W-1:0] woken_slot,
  output logic                            last_wake
);
  import ppst_pkg::*;

  localparam int SLOT_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
  localparam int CNT_W  = $clog2(NUM_SLOTS + 1);

  logic               rd_en;
  logic [SLOT_W-1:0]  rd_addr;
  logic [TICKS_W-1:0] rd_data;
  logic               wr_en;
  logic [SLOT_W-1:0]  wr_addr;
  logic [TICKS_W-1:0] wr_data;

  ppst_mem #(
    .NUM_SLOTS (NUM_SLOTS),
    .SLOT_W    (SLOT_W)
  ) u_mem (
    .clk     (clk),
    .rst     (rst),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data)
  );

  ppst_ctrl #(
    .NUM_SLOTS (NUM_SLOTS),
    .SLOT_W    (SLOT_W),
    .CNT_W     (CNT_W)
  ) u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .operation    (operation),
    .process_slot (process_slot),
    .sleep_ticks  (sleep_ticks),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .woken_slot   (woken_slot),
    .last_wake    (last_wake),
    .rd_en        (rd_en),
    .rd_addr      (rd_addr),
    .rd_data      (rd_data),
    .wr_en        (wr_en),
    .wr_addr      (wr_addr),
    .wr_data      (wr_data)
  );

endmodule
